>>> hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker of the cipher unit.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define RC4_CHECK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define RC4_CHECK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/rc4_pkg.sv
// Shared types and constants of the RC4 cipher unit.
// No dependencies.
package rc4_pkg;

  localparam int SBOX_DEPTH = 256;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] value;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_beat_t;

  // Requests from the sequencer to the key store.
  typedef struct packed {
    logic restart;
    logic rd_en;
    logic len_clear;
  } key_ctl_t;

endpackage

>>> hw/rtl/rc4_key_store.sv
// Key byte memory, key length counter and key read pointer.
// Depends on rc4_pkg.
module rc4_key_store import rc4_pkg::*; #(
  parameter int MAX_KEY_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_fire,
  input  in_beat_t   cmd,
  input  key_ctl_t   kctl,
  output logic [7:0] key_byte
);

  localparam int KIW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int KLW = $clog2(MAX_KEY_BYTES + 1);

  logic [7:0]     key_mem [MAX_KEY_BYTES];
  logic [KLW-1:0] key_len;
  logic [KIW-1:0] kpos;
  logic [KLW-1:0] len_eff;
  logic [KLW-1:0] kpos_inc;
  logic           wr_en;

  assign wr_en    = cmd_fire && (cmd.op == OP_KEY) && (key_len < KLW'(MAX_KEY_BYTES));
  // An empty key behaves as a one-byte key.
  assign len_eff  = (key_len == '0) ? KLW'(1) : key_len;
  assign kpos_inc = KLW'(kpos) + KLW'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[key_len[KIW-1:0]] <= cmd.value;
    end
    if (kctl.rd_en) begin
      key_byte <= key_mem[kpos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_len <= '0;
      kpos    <= '0;
    end else begin
      if (kctl.len_clear) begin
        key_len <= '0;
      end else if (wr_en) begin
        key_len <= key_len + KLW'(1);
      end
      if (kctl.restart) begin
        kpos <= '0;
      end else if (kctl.rd_en) begin
        kpos <= (kpos_inc >= len_eff) ? '0 : kpos_inc[KIW-1:0];
      end
    end
  end

endmodule

>>> hw/rtl/rc4_core.sv
// S-box memory, stream indices and the sequencer that drives one shared
// three-input adder through the key schedule and the keystream steps.
// Depends on rc4_pkg.
module rc4_core import rc4_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_fire,
  input  in_beat_t   cmd,
  input  logic [7:0] key_byte,
  output key_ctl_t   kctl,
  output logic       busy,
  input  logic       res_ready,
  output logic       res_valid,
  output out_beat_t  res
);

  typedef enum logic [9:0] {
    ST_FILL = 10'b0000000001,
    ST_IDLE = 10'b0000000010,
    ST_KA   = 10'b0000000100,
    ST_KB   = 10'b0000001000,
    ST_KC   = 10'b0000010000,
    ST_KD   = 10'b0000100000,
    ST_DA   = 10'b0001000000,
    ST_DB   = 10'b0010000000,
    ST_DC   = 10'b0100000000,
    ST_DD   = 10'b1000000000
  } state_t;

  state_t     state, state_next;
  logic [7:0] cnt;
  logic       sched;
  logic [7:0] idx_i, idx_j, s_i, s_j, pos;
  logic [7:0] dval;
  logic       dlast;

  logic [7:0] sbox [SBOX_DEPTH];
  logic       rd_en, wr_en;
  logic [7:0] rd_addr, wr_addr, wr_data, rdata;

  logic [7:0] add_a, add_b, add_c, sum;
  logic [7:0] ks;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sbox[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= sbox[rd_addr];
    end
  end

  // The one adder, shared by steps KB, DA, DB and DC.
  always_comb begin
    add_a = '0;
    add_b = '0;
    add_c = '0;
    unique case (state)
      ST_KB: begin
        add_a = idx_j;
        add_b = rdata;
        add_c = key_byte;
      end
      ST_DA: begin
        add_a = idx_i;
        add_c = 8'd1;
      end
      ST_DB: begin
        add_a = idx_j;
        add_b = rdata;
      end
      ST_DC: begin
        add_a = s_i;
        add_b = rdata;
      end
      default: begin
      end
    endcase
  end

  assign sum = add_a + add_b + add_c;

  always_comb begin
    state_next     = state;
    rd_en          = 1'b0;
    rd_addr        = sum;
    wr_en          = 1'b0;
    wr_addr        = cnt;
    wr_data        = cnt;
    kctl           = '0;
    unique case (state)
      ST_FILL: begin
        wr_en        = 1'b1;
        kctl.restart = 1'b1;
        if (cnt == 8'hFF) begin
          state_next = sched ? ST_KA : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_fire) begin
          if (cmd.op == OP_DATA) begin
            state_next = ST_DA;
          end else if (cmd.last) begin
            state_next = ST_FILL;
          end
        end
      end
      ST_KA: begin
        rd_en      = 1'b1;
        rd_addr    = cnt;
        kctl.rd_en = 1'b1;
        state_next = ST_KB;
      end
      ST_KB: begin
        rd_en      = 1'b1;
        state_next = ST_KC;
      end
      ST_KC: begin
        wr_en      = 1'b1;
        wr_data    = rdata;
        state_next = ST_KD;
      end
      ST_KD: begin
        wr_en   = 1'b1;
        wr_addr = idx_j;
        wr_data = s_i;
        if (cnt == 8'hFF) begin
          kctl.len_clear = 1'b1;
          state_next     = ST_IDLE;
        end else begin
          state_next = ST_KA;
        end
      end
      ST_DA: begin
        rd_en      = 1'b1;
        state_next = ST_DB;
      end
      ST_DB: begin
        rd_en      = 1'b1;
        state_next = ST_DC;
      end
      ST_DC: begin
        rd_en      = 1'b1;
        wr_en      = 1'b1;
        wr_addr    = idx_i;
        wr_data    = rdata;
        state_next = ST_DD;
      end
      ST_DD: begin
        wr_en   = 1'b1;
        wr_addr = idx_j;
        wr_data = s_i;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
      cnt   <= '0;
      sched <= 1'b0;
      idx_i <= '0;
      idx_j <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_FILL: begin
          cnt <= cnt + 8'd1;
          if (cnt == 8'hFF) begin
            idx_j <= '0;
          end
        end
        ST_IDLE: begin
          if (cmd_fire && (cmd.op == OP_KEY) && cmd.last) begin
            sched <= 1'b1;
            cnt   <= '0;
          end
        end
        ST_KB: idx_j <= sum;
        ST_KD: begin
          cnt <= cnt + 8'd1;
          if (cnt == 8'hFF) begin
            sched <= 1'b0;
            idx_i <= '0;
            idx_j <= '0;
          end
        end
        ST_DA: idx_i <= sum;
        ST_DB: idx_j <= sum;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_KB) || (state == ST_DB)) begin
      s_i <= rdata;
    end
    if (state == ST_DC) begin
      s_j <= rdata;
      pos <= sum;
    end
    if ((state == ST_IDLE) && cmd_fire) begin
      dval  <= cmd.value;
      dlast <= cmd.last;
    end
  end

  // The read of S[pos] was issued before the swap landed, so a hit on
  // either swapped entry takes the new value; the j write lands last.
  always_comb begin
    if (pos == idx_j) begin
      ks = s_i;
    end else if (pos == idx_i) begin
      ks = s_j;
    end else begin
      ks = rdata;
    end
  end

  assign busy         = (state != ST_IDLE);
  assign res_valid    = (state == ST_DD) && res_ready;
  assign res.out_byte = dval ^ ks;
  assign res.out_last = dlast;

endmodule

>>> hw/rtl/rc4_stream_cipher_unit.sv
// RC4 cipher unit: a plain key byte beat is only stored and leaves the unit
// idle; a data byte beat occupies the unit through steps DA, DB, DC and DD
// after acceptance, and a final key byte runs the key schedule (a pass that
// reloads the identity S-box, then steps KA to KD per swap). After reset the
// S-box is loaded with the identity in a pass during which cmd_ready stays
// low. These step sequences come from the single read and single write port
// of the S-box memory, which the sequencer visits once per step. A finished
// result sits in the output register, and a new command beat is taken while
// it waits. A data beat that finishes while that register still holds the
// previous result keeps the unit busy, with cmd_ready low, until the receiver
// takes that result, so a stall on the result channel lengthens the beat.
// Depends on rc4_pkg, rc4_key_store and rc4_core.
module rc4_stream_cipher_unit import rc4_pkg::*; #(
  parameter int MAX_KEY_BYTES = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  in_beat_t  cmd,
  output logic      res_valid,
  input  logic      res_ready,
  output out_beat_t res
);

  logic       cmd_fire;
  logic       busy;
  logic       core_res_ready;
  logic       core_res_valid;
  out_beat_t  core_res;
  key_ctl_t   kctl;
  logic [7:0] key_byte;

  assign cmd_ready      = !busy;
  assign cmd_fire       = cmd_valid && cmd_ready;
  assign core_res_ready = !res_valid || res_ready;

  rc4_key_store #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_key_store (
    .clk      (clk),
    .rst      (rst),
    .cmd_fire (cmd_fire),
    .cmd      (cmd),
    .kctl     (kctl),
    .key_byte (key_byte)
  );

  rc4_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cmd_fire  (cmd_fire),
    .cmd       (cmd),
    .key_byte  (key_byte),
    .kctl      (kctl),
    .busy      (busy),
    .res_ready (core_res_ready),
    .res_valid (core_res_valid),
    .res       (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (core_res_valid) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_res_valid) begin
      res <= core_res;
    end
  end

endmodule

>>> hw/rtl/rc4_checker.sv
// Port-level checks of the RC4 cipher unit, bound to the top level.
// Depends on rc4_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rc4_checker import rc4_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      cmd_valid,
  input logic      cmd_ready,
  input in_beat_t  cmd,
  input logic      res_valid,
  input logic      res_ready,
  input out_beat_t res
);

  logic cmd_fire;
  assign cmd_fire = cmd_valid && cmd_ready;

  // A stalled result beat keeps its payload.
  `RC4_CHECK(a_res_hold, clk, rst, (res_valid && !res_ready) |=> (res_valid && $stable(res)), "result beat changed while stalled")

  // Reset starts the identity pass with no result pending.
  `RC4_CHECK_ALWAYS(a_reset_busy, clk, rst |=> (!cmd_ready && !res_valid), "unit ready or result valid right after reset")

  // A data beat leaves the unit busy, with cmd_ready low.
  `RC4_CHECK(a_data_busy, clk, rst, (cmd_fire && (cmd.op == OP_DATA)) |=> !cmd_ready, "ready directly after a data beat")

  // A final key byte starts the schedule.
  `RC4_CHECK(a_sched_busy, clk, rst, (cmd_fire && (cmd.op == OP_KEY) && cmd.last) |=> !cmd_ready, "ready directly after the final key byte")

  // Other key bytes are only stored.
  `RC4_CHECK(a_key_ready, clk, rst, (cmd_fire && (cmd.op == OP_KEY) && !cmd.last) |=> cmd_ready, "not ready after a plain key byte")

endmodule

bind rc4_stream_cipher_unit rc4_checker u_rc4_checker (.*);

>>> test/rc4_stream_cipher_unit_checker.sv
// Checker for the RC4 cipher unit: watches both channels and predicts each
// ciphered data beat from its own copy of the S-box, key and indices.
// Depends on rc4_pkg.
module rc4_stream_cipher_unit_checker import rc4_pkg::*; #(
  parameter int MAX_KEY_BYTES = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  logic      cmd_ready,
  input  in_beat_t  cmd,
  input  logic      res_valid,
  input  logic      res_ready,
  input  out_beat_t res,
  output int        errors,
  output int        pending
);

  logic [7:0]  perm [SBOX_DEPTH];
  logic [7:0]  key_bytes [SBOX_DEPTH];
  int unsigned key_count;
  logic [7:0]  idx_i;
  logic [7:0]  idx_j;
  out_beat_t   cipher_q [$];
  out_beat_t   want;
  int          fail_count = 0;

  function void load_identity();
    int k;
    for (k = 0; k < SBOX_DEPTH; k++) perm[k] = k[7:0];
  endfunction

  function void swap_perm(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] t;
    t = perm[a];
    perm[a] = perm[b];
    perm[b] = t;
  endfunction

  function void run_key_schedule();
    int unsigned span;
    int unsigned kpos;
    int          n;
    logic [7:0]  jj;
    span = (key_count == 0) ? 1 : key_count;
    if (span > SBOX_DEPTH) span = SBOX_DEPTH;
    load_identity();
    jj = 8'd0;
    kpos = 0;
    for (n = 0; n < SBOX_DEPTH; n++) begin
      jj = jj + perm[n] + key_bytes[kpos];
      swap_perm(n[7:0], jj);
      kpos++;
      if (kpos >= span) kpos = 0;
    end
    idx_i = 8'd0;
    idx_j = 8'd0;
    key_count = 0;
  endfunction

  // Bytes past the key limit are dropped, but a dropped final byte still
  // starts the schedule.
  function void store_key_byte(input in_beat_t b);
    if (key_count < MAX_KEY_BYTES && key_count < SBOX_DEPTH) begin
      key_bytes[key_count] = b.value;
      key_count++;
    end
    if (b.last) run_key_schedule();
  endfunction

  function out_beat_t cipher_byte(input in_beat_t b);
    out_beat_t  r;
    logic [7:0] pos;
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + perm[idx_i];
    swap_perm(idx_i, idx_j);
    pos = perm[idx_i] + perm[idx_j];
    r.out_byte = b.value ^ perm[pos];
    r.out_last = b.last;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      load_identity();
      key_count = 0;
      idx_i = 8'd0;
      idx_j = 8'd0;
      cipher_q.delete();
    end else begin
      // A result can never leave on the edge its own data beat arrives, so
      // results are checked before the new beat is predicted.
      if (res_valid && res_ready) begin
        if (cipher_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result beat with no data beat pending: byte %02h last %0b",
                     res.out_byte, res.out_last);
        end else begin
          want = cipher_q.pop_front();
          if (res.out_byte !== want.out_byte || res.out_last !== want.out_last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("cipher beat mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                       want.out_byte, want.out_last, res.out_byte, res.out_last);
          end
        end
      end
      if (cmd_valid && cmd_ready) begin
        if (cmd.op == OP_DATA) cipher_q.push_back(cipher_byte(cmd));
        else store_key_byte(cmd);
      end
    end
    pending = cipher_q.size();
    errors = fail_count;
  end

endmodule

>>> test/rc4_stream_cipher_unit_test.sv
// Top of the RC4 cipher unit test: clock, reset, key and data stimulus,
// receiver back-pressure, watchdog and verdict.
// Depends on rc4_pkg, rc4_stream_cipher_unit and rc4_stream_cipher_unit_checker.
module rc4_stream_cipher_unit_test;
  import rc4_pkg::*;

  localparam int MAX_KEY_BYTES = 256;
  localparam int ITEM_TARGET   = 1600;
  localparam int CALM_AFTER    = 1450;
  localparam int STALL_LIMIT   = 20000;
  localparam int DRAIN_CYCLES  = 1400;
  localparam int HOLD_CYCLES   = 300;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid;
  logic      cmd_ready;
  in_beat_t  cmd;
  logic      res_valid;
  logic      res_ready;
  out_beat_t res;
  int        errors;
  int        pending;

  int sent = 0;
  bit calm = 1'b0;
  int hold_requests = 0;
  bit send_idle_on = 1'b1;

  always #1 clk = ~clk;

  rc4_stream_cipher_unit #(.MAX_KEY_BYTES(MAX_KEY_BYTES)) uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  rc4_stream_cipher_unit_checker #(.MAX_KEY_BYTES(MAX_KEY_BYTES)) cipher_check (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .errors    (errors),
    .pending   (pending)
  );

  // A steady beat never gets a gap in front of it.
  task automatic send_beat(input logic kind, input logic [7:0] val, input logic lst,
                           input bit steady);
    in_beat_t beat;
    beat.op = kind;
    beat.value = val;
    beat.last = lst;
    if (!steady && !calm && send_idle_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      cmd_valid <= 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk);
    end
    @(negedge clk);
    cmd_valid <= 1'b1;
    cmd <= beat;
    do @(posedge clk); while (!cmd_ready);
    sent++;
    if (sent >= CALM_AFTER) calm = 1'b1;
  endtask

  task automatic send_key(input int len, input bit interleave);
    int n;
    for (n = 0; n < len; n++) begin
      // Data between key bytes is still ciphered under the previous key.
      if (interleave && $urandom_range(0, 9) == 0)
        send_beat(OP_DATA, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
      send_beat(OP_KEY, 8'($urandom_range(0, 255)), n == len - 1, 1'b0);
    end
  endtask

  task automatic send_data(input int count, input bit steady);
    int n;
    for (n = 0; n < count; n++)
      send_beat(OP_DATA, 8'($urandom_range(0, 255)),
                (n == count - 1) || ($urandom_range(0, 15) == 0), steady);
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : receiver
    int burst_left;
    int seg_left;
    int served;
    bit idle_on;
    res_ready = 1'b0;
    burst_left = 0;
    seg_left = 0;
    served = 0;
    idle_on = 1'b0;
    forever begin
      @(negedge clk);
      if (seg_left == 0) begin
        seg_left = $urandom_range(50, 300);
        idle_on = ($urandom_range(0, 2) != 0);
      end
      seg_left--;
      if (served < hold_requests) begin
        // Long hold-off: the sender keeps offering data until the unit backs up.
        served++;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (calm) begin
        res_ready <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        res_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(0, 10);
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int seq;
    int roll;
    int n;
    cmd_valid = 1'b0;
    cmd = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Data before any key runs on the identity S-box.
    send_beat(OP_DATA, 8'h00, 1'b0, 1'b0);
    send_beat(OP_DATA, 8'hFF, 1'b1, 1'b0);
    send_beat(OP_DATA, 8'hA5, 1'b0, 1'b0);
    // One-byte keys at both extremes.
    send_beat(OP_KEY, 8'h00, 1'b1, 1'b0);
    send_beat(OP_DATA, 8'h00, 1'b1, 1'b0);
    send_beat(OP_DATA, 8'hFF, 1'b0, 1'b0);
    send_beat(OP_KEY, 8'hFF, 1'b1, 1'b0);
    send_beat(OP_DATA, 8'h00, 1'b0, 1'b0);
    send_beat(OP_KEY, 8'hFF, 1'b0, 1'b0);
    send_beat(OP_KEY, 8'h01, 1'b0, 1'b0);
    send_beat(OP_KEY, 8'h80, 1'b1, 1'b0);
    send_beat(OP_DATA, 8'h5A, 1'b0, 1'b0);
    send_beat(OP_DATA, 8'h00, 1'b0, 1'b0);
    send_beat(OP_DATA, 8'hFF, 1'b1, 1'b0);
    // A new key loaded between data beats that still use the old one.
    send_beat(OP_KEY, 8'h12, 1'b0, 1'b0);
    send_beat(OP_DATA, 8'h34, 1'b1, 1'b0);
    send_beat(OP_KEY, 8'hFE, 1'b0, 1'b0);
    send_beat(OP_DATA, 8'h00, 1'b0, 1'b0);
    send_beat(OP_KEY, 8'h7F, 1'b1, 1'b0);
    send_beat(OP_DATA, 8'hC3, 1'b0, 1'b0);
    send_beat(OP_DATA, 8'h3C, 1'b1, 1'b0);

    seq = 0;
    while (sent < ITEM_TARGET) begin
      send_idle_on = ($urandom_range(0, 3) != 0);
      roll = $urandom_range(0, 99);
      if (seq == 3 || seq == 11) begin
        send_key($urandom_range(1, 8), 1'b0);
        send_data(1, 1'b1);
        hold_requests++;
        send_data(40, 1'b1);
      end else if (seq == 6) begin
        send_key(MAX_KEY_BYTES, 1'b0);
        send_data(16, 1'b0);
      end else if (seq == 14) begin
        // Overlong key: the tail, final byte included, is dropped.
        send_key(MAX_KEY_BYTES + $urandom_range(1, 8), 1'b0);
        send_data(16, 1'b0);
      end else if (roll < 80) begin
        send_key((roll < 5) ? $urandom_range(17, 64) : $urandom_range(1, 16), roll % 4 == 0);
        send_data($urandom_range(8, 64), 1'b0);
      end else begin
        // Noise: stray data and partial keys that the next key continues.
        for (n = $urandom_range(1, 8); n > 0; n--) begin
          if ($urandom_range(0, 2) == 0)
            send_beat(OP_KEY, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
          else
            send_beat(OP_DATA, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
        end
      end
      seq++;
    end

    @(negedge clk);
    cmd_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
